// ----- design/rgb_to_hsv_unit_assert.svh -----
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_UNIT_ASSERT_SVH
`define RGB_TO_HSV_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define RTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_unit: check failed");
// Condition that must never hold outside reset.
`define RTH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rgb_to_hsv_unit: forbidden condition seen");
`else
`define RTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RTH_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- design/rth_pkg.sv -----
// Shared types and constants of the RGB to HSV converter.
package rth_pkg;

    localparam int ChanW   = 8;
    localparam int HueW    = 15;
    localparam int SatW    = 13;
    localparam int HueQW   = 15;   // hue quotient bits
    localparam int SatQW   = 13;   // saturation quotient bits
    localparam int AbsW    = 11;   // |sector * delta + num| up to 1275
    localparam int DvdW    = ChanW + HueQW;
    localparam int SatFracBits = 12;

    localparam logic [HueW-1:0] HueFullTurn = 15'd23040;
    localparam logic [SatW-1:0] SatOne      = 13'd4096;

    localparam int DefStepsPerStage = 4;

    // Word carried through the divider stages.
    typedef struct packed {
        logic [ChanW-1:0] h_rem;
        logic [HueQW-1:0] h_q;
        logic [ChanW-1:0] h_div;
        logic [ChanW-1:0] s_rem;
        logic [SatQW-1:0] s_q;
        logic [ChanW-1:0] s_div;
        logic             undef;
        logic             grey;
        logic             neg;
        logic [ChanW-1:0] brightness;
    } t_div_word;

endpackage

// ----- design/rth_ifs.sv -----
// Stream interfaces: pixel words in, HSV words out.
interface rth_pix_if;
    import rth_pkg::*;
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
    import rth_pkg::*;
    logic             valid;
    logic             ready;
    logic [HueW-1:0]  hue;
    logic             hue_undefined;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
    modport source (output valid, output hue, output hue_undefined, output saturation,
                    output brightness, input ready);
    modport sink   (input valid, input hue, input hue_undefined, input saturation,
                    input brightness, output ready);
endinterface

// ----- design/rth_prep.sv -----
// Front end: max/min/sector selection, then divider operand setup.
module rth_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    output logic                o_valid,
    input  logic                i_ready,
    output rth_pkg::t_div_word  o_data
);
    import rth_pkg::*;

    typedef enum logic [2:0] {
        SecRed   = 3'b001,
        SecGreen = 3'b010,
        SecBlue  = 3'b100
    } t_sector;

    typedef struct packed {
        logic [ChanW-1:0] mx;
        logic [ChanW-1:0] delta;
        t_sector          sector;
        logic [ChanW:0]   num;     // two's complement difference
    } t_sel_word;

    // stage A
    logic             r_a_valid;
    t_sel_word        r_a;
    t_sel_word        n_a;
    logic             a_en;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] mn;

    // stage B
    logic             r_b_valid;
    t_div_word        r_b;
    t_div_word        n_b;
    logic             b_en;
    logic [ChanW+1:0] sec_mul;
    logic [AbsW:0]    x;
    logic [AbsW-1:0]  abs_x;
    logic [DvdW-1:0]  dvd;

    assign b_en    = !r_b_valid || i_ready;
    assign a_en    = !r_a_valid || b_en;
    assign o_ready = a_en;
    assign o_valid = r_b_valid;
    assign o_data  = r_b;

    always_comb begin
        mx = (i_red >= i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = (i_red <= i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        n_a.mx    = mx;
        n_a.delta = mx - mn;
        // ties: red over green over blue
        if (i_red == mx) begin
            n_a.sector = SecRed;
            n_a.num    = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green == mx) begin
            n_a.sector = SecGreen;
            n_a.num    = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_a.sector = SecBlue;
            n_a.num    = {1'b0, i_red} - {1'b0, i_green};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_a <= n_a;
        end
    end

    always_comb begin
        case (r_a.sector)
            SecRed:   sec_mul = '0;
            SecGreen: sec_mul = {1'b0, r_a.delta, 1'b0};
            SecBlue:  sec_mul = {r_a.delta, 2'b00};
            default:  sec_mul = '0;
        endcase
        x     = {2'b00, sec_mul} + {{(AbsW-ChanW){r_a.num[ChanW]}}, r_a.num};
        abs_x = x[AbsW] ? AbsW'(-x) : x[AbsW-1:0];
        // 3840 * |x| as 4096*|x| - 256*|x|
        dvd   = {abs_x, 12'b0} - {4'b0, abs_x, 8'b0};

        n_b.h_rem      = dvd[DvdW-1:HueQW];
        n_b.h_q        = dvd[HueQW-1:0];
        n_b.h_div      = r_a.delta;
        // saturation dividend is delta << 12
        n_b.s_rem      = {1'b0, r_a.delta[ChanW-1:1]};
        n_b.s_q        = {r_a.delta[0], {SatFracBits{1'b0}}};
        n_b.s_div      = r_a.mx;
        n_b.undef      = (r_a.mx == '0);
        n_b.grey       = (r_a.delta == '0);
        n_b.neg        = x[AbsW];
        n_b.brightness = r_a.mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b <= n_b;
        end
    end

endmodule

// ----- design/rth_div_stage.sv -----
// One pipeline stage of the two restoring dividers (hue and saturation).
module rth_div_stage #(
    parameter int FIRST = 0,
    parameter int STEPS = rth_pkg::DefStepsPerStage
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rth_pkg::t_div_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rth_pkg::t_div_word  o_data
);
    import rth_pkg::*;

    logic      r_valid;
    t_div_word r_data;
    t_div_word n_data;
    logic      en;
    logic [ChanW:0] h_step;
    logic [ChanW:0] s_step;

    // returns {quotient bit, next remainder}
    function automatic logic [ChanW:0] rem_step(input logic [ChanW-1:0] rem,
                                                input logic             bit_in,
                                                input logic [ChanW-1:0] dvs);
        logic [ChanW:0] t;
        logic [ChanW:0] diff;
        logic           ge;
        t    = {rem, bit_in};
        diff = t - {1'b0, dvs};
        ge   = (t >= {1'b0, dvs});
        return {ge, ge ? diff[ChanW-1:0] : t[ChanW-1:0]};
    endfunction

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        h_step = '0;
        s_step = '0;
        for (int k = 0; k < STEPS; k++) begin
            if (FIRST + k < HueQW) begin
                h_step       = rem_step(n_data.h_rem, n_data.h_q[HueQW-1], n_data.h_div);
                n_data.h_rem = h_step[ChanW-1:0];
                n_data.h_q   = {n_data.h_q[HueQW-2:0], h_step[ChanW]};
            end
            if (FIRST + k < SatQW) begin
                s_step       = rem_step(n_data.s_rem, n_data.s_q[SatQW-1], n_data.s_div);
                n_data.s_rem = s_step[ChanW-1:0];
                n_data.s_q   = {n_data.s_q[SatQW-2:0], s_step[ChanW]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- design/rth_post.sv -----
// Back end: hue wrap and special cases, output register.
module rth_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rth_pkg::t_div_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [14:0]         o_hue,
    output logic                o_hue_undefined,
    output logic [12:0]         o_saturation,
    output logic [7:0]          o_brightness
);
    import rth_pkg::*;

    logic             r_valid;
    logic [HueW-1:0]  r_hue;
    logic             r_undef;
    logic [SatW-1:0]  r_sat;
    logic [ChanW-1:0] r_bright;
    logic [HueW-1:0]  n_hue;
    logic [SatW-1:0]  n_sat;
    logic             en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        if (i_data.undef || i_data.grey) begin
            n_hue = '0;
        end else if (i_data.neg) begin
            // negative angle: wrap by a full turn
            n_hue = (i_data.h_q == '0) ? '0 : HueFullTurn - i_data.h_q;
        end else begin
            n_hue = i_data.h_q;
        end
        n_sat = i_data.undef ? '0 : i_data.s_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue    <= n_hue;
            r_undef  <= i_data.undef;
            r_sat    <= n_sat;
            r_bright <= i_data.brightness;
        end
    end

    assign o_valid         = r_valid;
    assign o_hue           = r_hue;
    assign o_hue_undefined = r_undef;
    assign o_saturation    = r_sat;
    assign o_brightness    = r_bright;

endmodule

// ----- design/rgb_to_hsv_unit.sv -----
// Top level of the RGB to HSV converter.
// Takes one 8-bit RGB pixel word per clock unless the output stalls, and returns hue
// (1/64 degree, 0..23039), saturation (Q1.12, truncated), value (largest channel) and
// a flag for black, where hue is reported as 0. Throughput is one word per cycle
// unless stalled. Words pass prep stages A and B, the two restoring dividers and
// the output register; the dividers retire STEPS_PER_STAGE quotient bits per stage.
// Every stage has its own valid bit and a local ready, so a stalled output fills
// empty stages before input is held off; nothing is dropped or repeated.
`include "rgb_to_hsv_unit_assert.svh"
module rgb_to_hsv_unit #(
    parameter int STEPS_PER_STAGE = rth_pkg::DefStepsPerStage
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rth_pix_if.sink          i_pix,
    rth_hsv_if.source        o_hsv
);
    import rth_pkg::*;

    localparam int NumDivStages = (HueQW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    t_div_word w_data  [NumDivStages+1];
    logic      w_valid [NumDivStages+1];
    logic      w_ready [NumDivStages+1];

    rth_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    for (genvar j = 0; j < NumDivStages; j++) begin : g_div
        rth_div_stage #(
            .FIRST (j * STEPS_PER_STAGE),
            .STEPS (STEPS_PER_STAGE)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[j]),
            .o_ready (w_ready[j]),
            .i_data  (w_data[j]),
            .o_valid (w_valid[j+1]),
            .i_ready (w_ready[j+1]),
            .o_data  (w_data[j+1])
        );
    end

    rth_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid[NumDivStages]),
        .o_ready         (w_ready[NumDivStages]),
        .i_data          (w_data[NumDivStages]),
        .o_valid         (o_hsv.valid),
        .i_ready         (o_hsv.ready),
        .o_hue           (o_hsv.hue),
        .o_hue_undefined (o_hsv.hue_undefined),
        .o_saturation    (o_hsv.saturation),
        .o_brightness    (o_hsv.brightness)
    );

    `RTH_ASSERT_IMP(a_hue_range, i_clk, i_rst_n, o_hsv.valid, o_hsv.hue < HueFullTurn)
    `RTH_ASSERT_IMP(a_sat_range, i_clk, i_rst_n, o_hsv.valid, o_hsv.saturation <= SatOne)
    `RTH_ASSERT_IMP(a_black, i_clk, i_rst_n, o_hsv.valid && o_hsv.hue_undefined,
                    o_hsv.hue == '0 && o_hsv.saturation == '0 && o_hsv.brightness == '0)
    `RTH_ASSERT_IMP(a_zero_value, i_clk, i_rst_n, o_hsv.valid && o_hsv.brightness == '0,
                    o_hsv.hue_undefined)
    `RTH_ASSERT_NEVER(a_grey_hue, i_clk, i_rst_n,
                      o_hsv.valid && o_hsv.saturation == '0 && o_hsv.hue != '0)

endmodule
